FILE: rtl/mecanum_heading_kinematics_unit_assert.svh
// ----------------------------------------------------------------------------
// Mecanum heading kinematics assertion macros
// Clocked property shorthands for the port checker. They expect i_clk and
// i_rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef MECANUM_HEADING_KINEMATICS_UNIT_ASSERT_SVH
`define MECANUM_HEADING_KINEMATICS_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MHK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mhk checker: property violated");

// next-cycle implication, disabled during reset
`define MHK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mhk checker: property violated");

`endif

FILE: rtl/mhk_pkg.sv
// ----------------------------------------------------------------------------
// Mecanum heading kinematics package
// Field widths, CORDIC sizing, angle table and register codes.
// ----------------------------------------------------------------------------
package mhk_pkg;

    localparam int IN_W          = 16;
    localparam int SPD_W         = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_W         = 15;

    localparam int CORDIC_STAGES = 14;
    localparam int ATAN_LEN      = 24;
    localparam int SCALE_SH      = 8;
    localparam int XY_W          = 27;
    localparam int Z_W           = 26;

    typedef logic signed [Z_W-1:0] t_ang;

    localparam t_ang HALF_TURN  = t_ang'(8388608);
    localparam t_ang ROUND_HALF = t_ang'(128);

    localparam t_ang ATAN_TABLE [ATAN_LEN] = '{
        26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050,
        26'sd166669,  26'sd83416,   26'sd41718,  26'sd20860,
        26'sd10430,   26'sd5215,    26'sd2608,   26'sd1304,
        26'sd652,     26'sd326,     26'sd163,    26'sd81,
        26'sd41,      26'sd20,      26'sd10,     26'sd5,
        26'sd3,       26'sd1,       26'sd1,      26'sd0
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TWIST_GAIN      = 2'd0,
        CFG_CHASSIS_RADIUS  = 2'd1,
        CFG_MAX_WHEEL_SPEED = 2'd2
    } t_cfg_idx;

    localparam logic [15:0]      GAIN_RST   = 16'd256;
    localparam logic [15:0]      RADIUS_RST = 16'd4096;
    localparam logic [MAX_W-1:0] MAX_RST    = 15'd32767;

endpackage

FILE: rtl/mhk_stream_if.sv
// ----------------------------------------------------------------------------
// Mecanum heading kinematics stream interfaces
// Command channel and wheel speed channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface mhk_cmd_if;
    logic                            valid;
    logic                            ready;
    logic signed [mhk_pkg::IN_W-1:0] move_x;
    logic signed [mhk_pkg::IN_W-1:0] move_y;
    logic signed [mhk_pkg::IN_W-1:0] twist_x;
    logic signed [mhk_pkg::IN_W-1:0] twist_y;
    logic signed [mhk_pkg::IN_W-1:0] robot_heading;

    modport source (output valid, move_x, move_y, twist_x, twist_y, robot_heading,
                    input ready);
    modport sink (input valid, move_x, move_y, twist_x, twist_y, robot_heading,
                  output ready);
    modport monitor (input valid, ready, move_x, move_y, twist_x, twist_y, robot_heading);
endinterface

interface mhk_whl_if;
    logic                             valid;
    logic                             ready;
    logic signed [mhk_pkg::SPD_W-1:0] left_front_speed;
    logic signed [mhk_pkg::SPD_W-1:0] right_front_speed;
    logic signed [mhk_pkg::SPD_W-1:0] right_back_speed;
    logic signed [mhk_pkg::SPD_W-1:0] left_back_speed;
    logic signed [mhk_pkg::SPD_W-1:0] angular_rate;

    modport source (output valid, left_front_speed, right_front_speed, right_back_speed,
                    left_back_speed, angular_rate, input ready);
    modport sink (input valid, left_front_speed, right_front_speed, right_back_speed,
                  left_back_speed, angular_rate, output ready);
    modport monitor (input valid, ready, left_front_speed, right_front_speed,
                     right_back_speed, left_back_speed, angular_rate);
endinterface

FILE: rtl/mecanum_heading_kinematics_unit.sv
// ----------------------------------------------------------------------------
// Mecanum heading kinematics unit
// Takes one command beat per cycle while i_cmd.ready is high and returns one
// wheel speed beat for each. The pipeline is an entry register, the vectoring
// CORDIC with one register per iteration, the heading error stage, the gain
// multiplier, rate saturation, the radius multiplier and the wheel clamp. The
// result sits in an output register backed by a one-beat skid stage;
// i_cmd.ready drops only while that skid stage holds a beat. Configuration
// registers are read live by the datapath; the user must write them only
// while no beat is in flight, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module mecanum_heading_kinematics_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mhk_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mhk_pkg::CFG_W-1:0]     i_cfg_data,
    mhk_cmd_if.sink                       i_cmd,
    mhk_whl_if.source                     o_whl
);
    import mhk_pkg::*;

    localparam int LAST  = CORDIC_STAGES + 5;
    localparam int D_W   = Z_W - SCALE_SH;
    localparam int E_W   = 17;
    localparam int GP_W  = 32;
    localparam int RP_W  = 32;
    localparam int T_W   = RP_W - 12;
    localparam int W_W   = 21;
    localparam int XY_PAD = XY_W - IN_W - SCALE_SH;

    typedef struct packed {
        logic signed [SPD_W-1:0] lf;
        logic signed [SPD_W-1:0] rf;
        logic signed [SPD_W-1:0] rb;
        logic signed [SPD_W-1:0] lb;
        logic signed [SPD_W-1:0] rate;
    } t_whl;

    localparam logic signed [D_W-1:0]  D_HALF   = D_W'(32768);
    localparam logic signed [D_W-1:0]  D_TURN   = D_W'(65536);
    localparam logic signed [GP_W-1:0] RATE_MAX = GP_W'(32767);

    // configuration
    logic [15:0]      r_gain;
    logic [15:0]      r_radius;
    logic [MAX_W-1:0] r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RST;
            r_radius <= RADIUS_RST;
            r_max    <= MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TWIST_GAIN:      r_gain   <= i_cfg_data[15:0];
                CFG_CHASSIS_RADIUS:  r_radius <= i_cfg_data[15:0];
                CFG_MAX_WHEEL_SPEED: r_max    <= i_cfg_data[MAX_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [LAST:0] r_vld;
    logic          r_skid_vld;
    logic          adv;
    t_whl          r_last;
    t_whl          r_skid;
    t_whl          n_last;

    assign adv         = !r_skid_vld;
    assign i_cmd.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_skid_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_vld <= {r_vld[LAST-1:0], i_cmd.valid};
            end
            if (adv && r_vld[LAST] && !o_whl.ready) begin
                r_skid_vld <= 1'b1;
            end else if (r_skid_vld && o_whl.ready) begin
                r_skid_vld <= 1'b0;
            end
        end
    end

    // CORDIC entry: scale and fold the left half plane
    logic signed [XY_W-1:0] sx, sy;
    logic signed [XY_W-1:0] n_cx0, n_cy0;
    t_ang                   n_cz0;
    logic                   n_zero0;

    assign sx = {{XY_PAD{i_cmd.twist_x[IN_W-1]}}, i_cmd.twist_x, {SCALE_SH{1'b0}}};
    assign sy = {{XY_PAD{i_cmd.twist_y[IN_W-1]}}, i_cmd.twist_y, {SCALE_SH{1'b0}}};
    assign n_zero0 = (i_cmd.twist_x == '0) && (i_cmd.twist_y == '0);

    always_comb begin
        n_cx0 = sx;
        n_cy0 = sy;
        n_cz0 = '0;
        if (i_cmd.twist_x[IN_W-1]) begin
            n_cz0 = i_cmd.twist_y[IN_W-1] ? -HALF_TURN : HALF_TURN;
            n_cx0 = -sx;
            n_cy0 = -sy;
        end
    end

    logic signed [XY_W-1:0] r_cx [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] r_cy [CORDIC_STAGES+1];
    t_ang                   r_cz [CORDIC_STAGES+1];
    logic                   r_zero [CORDIC_STAGES+1];
    logic signed [IN_W-1:0] r_hd [CORDIC_STAGES+1];
    logic signed [IN_W-1:0] r_mx [LAST];
    logic signed [IN_W-1:0] r_my [LAST];

    logic signed [XY_W-1:0] n_cx [CORDIC_STAGES];
    logic signed [XY_W-1:0] n_cy [CORDIC_STAGES];
    t_ang                   n_cz [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        logic signed [XY_W-1:0] xs, ys;
        logic                   neg;
        assign xs  = r_cx[i] >>> i;
        assign ys  = r_cy[i] >>> i;
        assign neg = r_cy[i][XY_W-1];
        assign n_cx[i] = neg ? (r_cx[i] - ys) : (r_cx[i] + ys);
        assign n_cy[i] = neg ? (r_cy[i] + xs) : (r_cy[i] - xs);
        assign n_cz[i] = neg ? (r_cz[i] - ATAN_TABLE[i]) : (r_cz[i] + ATAN_TABLE[i]);
    end

    // heading error: round, wrap, subtract, wrap
    t_ang                   zr;
    logic signed [D_W-1:0]  d_raw, d_wrap, hd_ext, e_raw, e_wrap;
    logic signed [E_W-1:0]  n_err;

    assign zr     = r_cz[CORDIC_STAGES] + ROUND_HALF;
    assign d_raw  = $signed(zr[Z_W-1:SCALE_SH]);
    assign hd_ext = D_W'(r_hd[CORDIC_STAGES]);

    always_comb begin
        d_wrap = d_raw;
        if (d_raw > D_HALF) begin
            d_wrap = d_raw - D_TURN;
        end else if (d_raw <= -D_HALF) begin
            d_wrap = d_raw + D_TURN;
        end
        if (r_zero[CORDIC_STAGES]) begin
            d_wrap = '0;
        end
        e_raw  = d_wrap - hd_ext;
        e_wrap = e_raw;
        if (e_raw > D_HALF) begin
            e_wrap = e_raw - D_TURN;
        end else if (e_raw < -D_HALF) begin
            e_wrap = e_raw + D_TURN;
        end
        n_err = e_wrap[E_W-1:0];
    end

    // gain, saturation, radius
    logic signed [E_W-1:0]   r_err;
    logic signed [GP_W-1:0]  r_gprod;
    logic signed [SPD_W-1:0] r_rate;
    logic signed [SPD_W-1:0] r_prate;
    logic signed [RP_W-1:0]  r_rprod;

    logic signed [2*E_W:0]     gfull;
    logic signed [GP_W-1:0]    gsh;
    logic signed [SPD_W-1:0]   n_rate;
    logic signed [2*SPD_W:0]   rfull;

    assign gfull = $signed({1'b0, r_gain}) * r_err;
    assign gsh   = r_gprod >>> 8;

    always_comb begin
        if (gsh > RATE_MAX) begin
            n_rate = SPD_W'(32767);
        end else if (gsh < -RATE_MAX) begin
            n_rate = -SPD_W'(32767);
        end else begin
            n_rate = gsh[SPD_W-1:0];
        end
    end

    assign rfull = $signed({1'b0, r_radius}) * r_rate;

    // wheel sums and clamp
    logic signed [T_W-1:0] term;
    logic signed [W_W-1:0] term_ext, mx_ext, my_ext, lim;
    logic signed [W_W-1:0] s_lf, s_rf, s_rb, s_lb;

    function automatic logic signed [SPD_W-1:0] clamp_spd(
        input logic signed [W_W-1:0] v,
        input logic signed [W_W-1:0] l
    );
        if (v > l) begin
            return l[SPD_W-1:0];
        end else if (v < -l) begin
            return SPD_W'(-l);
        end
        return v[SPD_W-1:0];
    endfunction

    assign term     = $signed(r_rprod[RP_W-1:12]);
    assign term_ext = W_W'(term);
    assign mx_ext   = W_W'(r_mx[LAST-1]);
    assign my_ext   = W_W'(r_my[LAST-1]);
    assign lim      = $signed({{(W_W-MAX_W){1'b0}}, r_max});

    assign s_lf = -mx_ext - my_ext + term_ext;
    assign s_rf =  mx_ext - my_ext + term_ext;
    assign s_rb =  mx_ext + my_ext + term_ext;
    assign s_lb = -mx_ext + my_ext + term_ext;

    always_comb begin
        n_last.lf   = clamp_spd(s_lf, lim);
        n_last.rf   = clamp_spd(s_rf, lim);
        n_last.rb   = clamp_spd(s_rb, lim);
        n_last.lb   = clamp_spd(s_lb, lim);
        n_last.rate = r_prate;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cx[0]   <= n_cx0;
            r_cy[0]   <= n_cy0;
            r_cz[0]   <= n_cz0;
            r_zero[0] <= n_zero0;
            r_hd[0]   <= i_cmd.robot_heading;
            r_mx[0]   <= i_cmd.move_x;
            r_my[0]   <= i_cmd.move_y;
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                r_cx[k+1]   <= n_cx[k];
                r_cy[k+1]   <= n_cy[k];
                r_cz[k+1]   <= n_cz[k];
                r_zero[k+1] <= r_zero[k];
                r_hd[k+1]   <= r_hd[k];
            end
            for (int k = 0; k < LAST-1; k++) begin
                r_mx[k+1] <= r_mx[k];
                r_my[k+1] <= r_my[k];
            end
            r_err   <= n_err;
            r_gprod <= gfull[GP_W-1:0];
            r_rate  <= n_rate;
            r_prate <= r_rate;
            r_rprod <= rfull[RP_W-1:0];
            r_last  <= n_last;
            if (r_vld[LAST] && !o_whl.ready) begin
                r_skid <= r_last;
            end
        end
    end

    // output select: skid beat goes first
    t_whl out_beat;
    assign out_beat = r_skid_vld ? r_skid : r_last;

    assign o_whl.valid             = r_skid_vld || r_vld[LAST];
    assign o_whl.left_front_speed  = out_beat.lf;
    assign o_whl.right_front_speed = out_beat.rf;
    assign o_whl.right_back_speed  = out_beat.rb;
    assign o_whl.left_back_speed   = out_beat.lb;
    assign o_whl.angular_rate      = out_beat.rate;

endmodule

FILE: rtl/mhk_checker.sv
// ----------------------------------------------------------------------------
// Mecanum heading kinematics port checker
// Watches the command and wheel channels of the top level and flags
// handshake and skid-stage slips.
// ----------------------------------------------------------------------------
`include "mecanum_heading_kinematics_unit_assert.svh"

module mhk_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cmd_ready,
    input logic                         i_whl_valid,
    input logic                         i_whl_ready,
    input logic [5*mhk_pkg::SPD_W-1:0]  i_whl_beat
);

    `MHK_ASSERT_NEXT(a_whl_valid_hold, i_whl_valid && !i_whl_ready, i_whl_valid)

    `MHK_ASSERT_NEXT(a_whl_beat_hold, i_whl_valid && !i_whl_ready, $stable(i_whl_beat))

    `MHK_ASSERT_NOW(a_ready_drop_on_stall, $fell(i_cmd_ready), $past(i_whl_valid && !i_whl_ready))

    `MHK_ASSERT_NOW(a_busy_has_beat, !i_cmd_ready, i_whl_valid)

endmodule

bind mecanum_heading_kinematics_unit mhk_checker u_mhk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_ready (i_cmd.ready),
    .i_whl_valid (o_whl.valid),
    .i_whl_ready (o_whl.ready),
    .i_whl_beat  ({o_whl.left_front_speed, o_whl.right_front_speed, o_whl.right_back_speed,
                   o_whl.left_back_speed, o_whl.angular_rate})
);

FILE: bench/mecanum_heading_kinematics_unit_tb.sv
// ----------------------------------------------------------------------------
// Mecanum heading kinematics unit testbench
// Streams command beats into the unit under random source gaps and sink
// stalls, including one long sink hold-off that backs the pipeline up. A
// scoreboard model computes the CORDIC heading, wrapped heading error, rate
// and four clamped wheel speeds for every accepted beat. Each output beat is
// checked field by field against the oldest prediction. Register settings
// change between batches while the unit is idle, covering gain, radius and
// clamp extremes, an unmapped register index and data bits above the width.
// ----------------------------------------------------------------------------
module mecanum_heading_kinematics_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mhk_pkg::*;

    localparam int     CLK_PERIOD   = 10;
    localparam int     RST_CYCLES   = 9;
    localparam int     DRAIN_CYCLES = CORDIC_STAGES + 10;
    localparam int     HOLD_AT_BEAT = 80;
    localparam int     HOLD_CYCLES  = 300;
    localparam longint CYCLE_LIMIT  = 300000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam longint HEADING_HALF_TURN = 8388608;
    localparam longint HEADING_ATAN [24] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0
    };
    localparam int FIELD_EXTREMES [6] = '{-32768, -32767, -1, 0, 1, 32767};

    typedef struct packed {
        logic signed [IN_W-1:0] move_x;
        logic signed [IN_W-1:0] move_y;
        logic signed [IN_W-1:0] twist_x;
        logic signed [IN_W-1:0] twist_y;
        logic signed [IN_W-1:0] robot_heading;
    } t_cmd;

    typedef struct packed {
        logic signed [SPD_W-1:0] left_front_speed;
        logic signed [SPD_W-1:0] right_front_speed;
        logic signed [SPD_W-1:0] right_back_speed;
        logic signed [SPD_W-1:0] left_back_speed;
        logic signed [SPD_W-1:0] angular_rate;
    } t_wheels;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    mhk_cmd_if cmd_if ();
    mhk_whl_if whl_if ();

    mecanum_heading_kinematics_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_whl      (whl_if)
    );

    logic [15:0]      gain_reg   = GAIN_RST;
    logic [15:0]      radius_reg = RADIUS_RST;
    logic [MAX_W-1:0] max_reg    = MAX_RST;

    t_cmd    cmd_pending [$];
    t_wheels wheels_expected [$];

    bit     steady;
    bit     sink_hold;
    bit     hold_done;
    int     cmd_gap;
    int     beats_seen;
    int     hold_left;
    int     stall_left;
    int     mismatch_count;
    longint cycle_count;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint desired_heading(input longint ty, input longint tx);
        longint x, y, z, xs, ys, d;
        if (tx == 0 && ty == 0) return 0;
        x = tx * 256;
        y = ty * 256;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? HEADING_HALF_TURN : -HEADING_HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += HEADING_ATAN[i];
            end else begin
                x -= ys;
                y += xs;
                z -= HEADING_ATAN[i];
            end
        end
        d = (z + 128) >>> 8;
        if (d > 32768) d -= 65536;
        if (d <= -32768) d += 65536;
        return d;
    endfunction

    function automatic t_wheels predict_wheels(input t_cmd c);
        longint  err, rate, term, lim, mx, my;
        t_wheels w;
        mx  = longint'($signed(c.move_x));
        my  = longint'($signed(c.move_y));
        lim = longint'(max_reg);
        err = desired_heading(longint'($signed(c.twist_y)), longint'($signed(c.twist_x)))
              - longint'($signed(c.robot_heading));
        if (err > 32768) err -= 65536;
        if (err < -32768) err += 65536;
        rate = clamp_to((longint'(gain_reg) * err) >>> 8, -32767, 32767);
        term = (longint'(radius_reg) * rate) >>> 12;
        w.left_front_speed  = SPD_W'(clamp_to(-mx - my + term, -lim, lim));
        w.right_front_speed = SPD_W'(clamp_to(mx - my + term, -lim, lim));
        w.right_back_speed  = SPD_W'(clamp_to(mx + my + term, -lim, lim));
        w.left_back_speed   = SPD_W'(clamp_to(-mx + my + term, -lim, lim));
        w.angular_rate      = SPD_W'(rate);
        return w;
    endfunction

    function automatic logic signed [IN_W-1:0] rand_field();
        case ($urandom_range(0, 9))
            0, 1:    return IN_W'(FIELD_EXTREMES[$urandom_range(0, 5)]);
            2, 3, 4: return IN_W'(int'($urandom_range(0, 512)) - 256);
            default: return IN_W'($urandom);
        endcase
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        c.move_x        = rand_field();
        c.move_y        = rand_field();
        c.twist_x       = rand_field();
        c.twist_y       = rand_field();
        c.robot_heading = rand_field();
        if ($urandom_range(0, 19) == 0) begin
            c.twist_x = '0;
            c.twist_y = '0;
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic signed [SPD_W-1:0] got,
                               input logic signed [SPD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_TWIST_GAIN:      gain_reg   = data;
            CFG_CHASSIS_RADIUS:  radius_reg = data;
            CFG_MAX_WHEEL_SPEED: max_reg    = data[MAX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (cmd_pending.size() != 0 || cmd_if.valid || wheels_expected.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_batch(input int n, input bit calm);
        @(negedge i_clk);
        steady = calm;
        repeat (n) cmd_pending.push_back(random_cmd());
        wait_idle();
    endtask

    function automatic t_cmd mk_cmd(input int mx, input int my, input int tx, input int ty,
                                    input int hd);
        t_cmd c;
        c.move_x        = IN_W'(mx);
        c.move_y        = IN_W'(my);
        c.twist_x       = IN_W'(tx);
        c.twist_y       = IN_W'(ty);
        c.robot_heading = IN_W'(hd);
        return c;
    endfunction

    // source side: present queued beats, idle between them
    always @(posedge i_clk) begin : cmd_driver
        t_cmd cmd_beat;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            cmd_gap = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready)
                wheels_expected.push_back(predict_wheels(cmd_beat));
            if (!cmd_if.valid || cmd_if.ready) begin
                if (cmd_gap > 0) begin
                    cmd_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (cmd_pending.size() != 0) begin
                    cmd_beat = cmd_pending.pop_front();
                    cmd_if.valid         <= 1'b1;
                    cmd_if.move_x        <= cmd_beat.move_x;
                    cmd_if.move_y        <= cmd_beat.move_y;
                    cmd_if.twist_x       <= cmd_beat.twist_x;
                    cmd_if.twist_y       <= cmd_beat.twist_y;
                    cmd_if.robot_heading <= cmd_beat.robot_heading;
                    cmd_gap = steady ? 0 : pick_gap();
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // long sink hold-off, started once enough beats have come out
    always @(posedge i_clk) begin : sink_hold_off
        if (hold_left > 0) begin
            hold_left--;
        end else if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        sink_hold <= (hold_left > 0);
    end

    // sink side: check each beat, stall at random
    always @(posedge i_clk) begin : whl_monitor
        t_wheels got, want;
        int      n;
        if (!i_rst_n) begin
            whl_if.ready <= 1'b0;
        end else begin
            if (whl_if.valid && whl_if.ready) begin
                got.left_front_speed  = whl_if.left_front_speed;
                got.right_front_speed = whl_if.right_front_speed;
                got.right_back_speed  = whl_if.right_back_speed;
                got.left_back_speed   = whl_if.left_back_speed;
                got.angular_rate      = whl_if.angular_rate;
                if (wheels_expected.size() == 0) begin
                    report_mismatch("output beat with no command pending");
                end else begin
                    want = wheels_expected.pop_front();
                    check_field("left_front_speed", got.left_front_speed,
                                want.left_front_speed);
                    check_field("right_front_speed", got.right_front_speed,
                                want.right_front_speed);
                    check_field("right_back_speed", got.right_back_speed,
                                want.right_back_speed);
                    check_field("left_back_speed", got.left_back_speed,
                                want.left_back_speed);
                    check_field("angular_rate", got.angular_rate, want.angular_rate);
                end
                beats_seen++;
            end
            if (sink_hold) begin
                whl_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                whl_if.ready <= 1'b0;
            end else if (steady) begin
                whl_if.ready <= 1'b1;
            end else begin
                n = pick_gap();
                if (n == 0) begin
                    whl_if.ready <= 1'b1;
                end else begin
                    stall_left = n - 1;
                    whl_if.ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = '0;
        i_cfg_data           = '0;
        steady               = 1'b0;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats at reset settings
        @(negedge i_clk);
        cmd_pending.push_back(mk_cmd(0, 0, 0, 0, 0));
        cmd_pending.push_back(mk_cmd(32767, 32767, 32767, 32767, 32767));
        cmd_pending.push_back(mk_cmd(-32768, -32768, -32768, -32768, -32768));
        cmd_pending.push_back(mk_cmd(32767, 32767, 1, 0, -32768));
        cmd_pending.push_back(mk_cmd(-32768, -32768, -1, 0, -32768));
        cmd_pending.push_back(mk_cmd(100, -200, -100, 0, 1));
        cmd_pending.push_back(mk_cmd(-300, 400, -100, -1, 32767));
        cmd_pending.push_back(mk_cmd(32767, -32768, 0, 5, 0));
        cmd_pending.push_back(mk_cmd(-32768, 32767, 0, -5, 16384));
        cmd_pending.push_back(mk_cmd(1, -1, -32768, -32768, -32767));
        cmd_pending.push_back(mk_cmd(-1, 1, 32767, -32768, 0));
        cmd_pending.push_back(mk_cmd(0, 0, -32768, 32767, -16384));
        cmd_pending.push_back(mk_cmd(500, 500, -1, 1, 0));
        cmd_pending.push_back(mk_cmd(-500, -500, 1, -1, 0));
        cmd_pending.push_back(mk_cmd(0, 32767, 0, 0, 32767));
        cmd_pending.push_back(mk_cmd(32767, 0, 0, 0, -32768));
        cmd_pending.push_back(mk_cmd(12345, -12345, 3, 4, 0));
        cmd_pending.push_back(mk_cmd(-1, -1, -32768, 0, 32767));
        cmd_pending.push_back(mk_cmd(0, 0, -32768, -1, -32768));
        cmd_pending.push_back(mk_cmd(20000, 20000, 32767, 1, -1));
        wait_idle();

        run_batch(50, 1'b0);

        write_reg(CFG_TWIST_GAIN, 16'hFFFF);
        write_reg(CFG_CHASSIS_RADIUS, 16'hFFFF);
        write_reg(CFG_MAX_WHEEL_SPEED, 16'h7FFF);
        run_batch(45, 1'b1);

        write_reg(CFG_TWIST_GAIN, 16'd512);
        write_reg(CFG_CHASSIS_RADIUS, 16'd0);
        write_reg(CFG_MAX_WHEEL_SPEED, 16'd20000);
        run_batch(35, 1'b0);

        write_reg(CFG_TWIST_GAIN, 16'd1);
        write_reg(CFG_CHASSIS_RADIUS, 16'd1);
        write_reg(CFG_MAX_WHEEL_SPEED, 16'd0);
        run_batch(35, 1'b0);

        write_reg(CFG_TWIST_GAIN, 16'd0);
        write_reg(CFG_CHASSIS_RADIUS, 16'h8000);
        write_reg(CFG_MAX_WHEEL_SPEED, 16'hC123);
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        run_batch(35, 1'b1);

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_TWIST_GAIN, CFG_W'($urandom));
            write_reg(CFG_CHASSIS_RADIUS, CFG_W'($urandom));
            write_reg(CFG_MAX_WHEEL_SPEED, CFG_W'($urandom));
            if (p == 3) write_reg(CFG_UNMAPPED, CFG_W'($urandom));
            run_batch(40, p[0]);
        end

        if (wheels_expected.size() != 0)
            report_mismatch($sformatf("%0d predictions never matched by an output beat",
                                      wheels_expected.size()));

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: mecanum_heading_kinematics_unit.f
+incdir+rtl
rtl/mhk_pkg.sv
rtl/mhk_stream_if.sv
rtl/mecanum_heading_kinematics_unit.sv
rtl/mhk_checker.sv
bench/mecanum_heading_kinematics_unit_tb.sv
